[sv/drbl_pkg.sv]
// ----------------------------------------------------------------------------
// drbl_pkg
// Shared widths, register indexes, outcome codes and the config record of
// the dram row buffer latency model.
// ----------------------------------------------------------------------------
package drbl_pkg;

	localparam int ADDR_W = 48;
	localparam int ROW_W = 44;
	localparam int CNT_W = 48;
	localparam int LAT_W = 12;
	localparam int TIM_W = 10;
	localparam int LSZ_W = 4;
	localparam int OUTC_W = 2;
	localparam int APB_DW = 32;
	localparam int APB_AW = 5;
	localparam int SHAMT_W = 5;

	localparam logic [LAT_W-1:0] FIXED_DELAY = 12'd100;

	// row outcome codes
	localparam logic [OUTC_W-1:0] OUTC_HIT      = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_EMPTY    = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_CONFLICT = 2'd2;
	localparam logic [OUTC_W-1:0] OUTC_FIXED    = 2'd3;

	// register indexes (byte address is 4 times the index)
	localparam logic [2:0] REG_ACCESS_MODE = 3'd0;
	localparam logic [2:0] REG_PAGE_POLICY = 3'd1;
	localparam logic [2:0] REG_CAS         = 3'd2;
	localparam logic [2:0] REG_RAS         = 3'd3;
	localparam logic [2:0] REG_PRECHARGE   = 3'd4;
	localparam logic [2:0] REG_BUS         = 3'd5;
	localparam logic [2:0] REG_LINE_SIZE   = 3'd6;

	typedef struct packed {
		logic             access_mode;
		logic             page_policy;
		logic [TIM_W-1:0] cas_latency;
		logic [TIM_W-1:0] ras_latency;
		logic [TIM_W-1:0] precharge_latency;
		logic [TIM_W-1:0] bus_latency;
		logic [LSZ_W-1:0] line_size_log2;
	} cfg_t;

endpackage

[sv/drbl_ifs.sv]
// ----------------------------------------------------------------------------
// drbl interfaces
// Valid/ready channels for access words and result words.
// ----------------------------------------------------------------------------
interface drbl_req_if;
	logic                        valid;
	logic                        ready;
	logic [drbl_pkg::ADDR_W-1:0] line_address;
	logic                        is_write;

	modport source (output valid, output line_address, output is_write, input ready);
	modport sink (input valid, input line_address, input is_write, output ready);
endinterface

interface drbl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [drbl_pkg::LAT_W-1:0]  latency;
	logic [drbl_pkg::OUTC_W-1:0] row_outcome;
	logic [drbl_pkg::CNT_W-1:0]  reads_total;
	logic [drbl_pkg::CNT_W-1:0]  read_delay_total;
	logic [drbl_pkg::CNT_W-1:0]  writes_total;
	logic [drbl_pkg::CNT_W-1:0]  write_delay_total;

	modport source (output valid, output latency, output row_outcome, output reads_total,
		output read_delay_total, output writes_total, output write_delay_total,
		input ready);
	modport sink (input valid, input latency, input row_outcome, input reads_total,
		input read_delay_total, input writes_total, input write_delay_total,
		output ready);
endinterface

[sv/dram_row_buffer_latency_model.sv]
// ----------------------------------------------------------------------------
// dram_row_buffer_latency_model
// Open row buffer timing model: one dram access word in, one latency word out.
// ----------------------------------------------------------------------------
// req carries a line address and a read/write flag; rsp returns the latency,
// the row outcome (hit, empty bank, conflict, fixed mode) and the running
// read/write counts and delay sums after that access.
// An accepted word goes into the input register, where bank and row are
// already split off; the bank table lookup, latency sum and counter update
// then load the result register.
// Throughput is one word per cycle while rsp is not stalled: the bank table
// is a flop register file read and written in the same cycle, so
// back-to-back accesses to one bank see each other.
// When rsp is stalled the result register holds and the input register
// keeps one more word; req.ready drops only when both are full.
// Reset empties both registers, closes every bank and clears the counters;
// config registers return to their defaults. The APB port takes writes at
// any time but is meant to be written only while the block is idle.
// ----------------------------------------------------------------------------
module dram_row_buffer_latency_model #(
	parameter int BANKS = 16,
	parameter int COLUMNS_PER_ROW = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	drbl_req_if.sink                    req,
	drbl_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [drbl_pkg::APB_AW-1:0] paddr,
	input  logic [drbl_pkg::APB_DW-1:0] pwdata,
	output logic [drbl_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int BANK_LOG2 = $clog2(BANKS);
	localparam int BANK_W = (BANKS > 1) ? BANK_LOG2 : 1;
	localparam int COL_LOG2 = $clog2(COLUMNS_PER_ROW);

	drbl_pkg::cfg_t cfg;

	// input stage
	logic                        valid_s1;
	logic [BANK_W-1:0]           bank_s1;
	logic [drbl_pkg::ROW_W-1:0]  row_s1;
	logic                        is_write_s1;

	logic [BANK_W-1:0]            bank_in;
	logic [drbl_pkg::SHAMT_W-1:0] line_bits;
	logic [drbl_pkg::SHAMT_W-1:0] shamt;
	logic [drbl_pkg::ADDR_W-1:0]  shifted;

	// result stage
	logic                        rsp_valid_q;
	logic [drbl_pkg::LAT_W-1:0]  latency_q;
	logic [drbl_pkg::OUTC_W-1:0] outcome_q;

	logic                        out_adv;
	logic                        commit;
	logic [drbl_pkg::OUTC_W-1:0] bank_outcome;
	logic [drbl_pkg::OUTC_W-1:0] outcome;
	logic [drbl_pkg::LAT_W-1:0]  delay;

	drbl_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// row = address >> (log2 lines per row + log2 banks), one line per row at least
	always_comb begin
		if ({1'b0, cfg.line_size_log2} >= drbl_pkg::SHAMT_W'(COL_LOG2)) begin
			line_bits = '0;
		end else begin
			line_bits = drbl_pkg::SHAMT_W'(COL_LOG2) - {1'b0, cfg.line_size_log2};
		end
		shamt = line_bits + drbl_pkg::SHAMT_W'(BANK_LOG2);
		shifted = req.line_address >> shamt;
		if (BANKS > 1) begin
			bank_in = req.line_address[BANK_W-1:0];
		end else begin
			bank_in = '0;
		end
	end

	assign out_adv = !rsp_valid_q || rsp.ready;
	assign commit = valid_s1 && out_adv;
	assign req.ready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			bank_s1 <= bank_in;
			row_s1 <= shifted[drbl_pkg::ROW_W-1:0];
			is_write_s1 <= req.is_write;
		end
	end

	drbl_bank_table #(
		.BANKS  (BANKS),
		.BANK_W (BANK_W)
	) u_banks (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (commit && cfg.access_mode),
		.bank    (bank_s1),
		.row     (row_s1),
		.outcome (bank_outcome)
	);

	always_comb begin
		if (!cfg.access_mode) begin
			outcome = drbl_pkg::OUTC_FIXED;
			delay = drbl_pkg::FIXED_DELAY;
		end else begin
			outcome = bank_outcome;
			delay = 12'(cfg.bus_latency) + 12'(cfg.cas_latency);
			if (cfg.page_policy || bank_outcome != drbl_pkg::OUTC_HIT) begin
				delay = delay + 12'(cfg.ras_latency);
			end
			if (!cfg.page_policy && bank_outcome == drbl_pkg::OUTC_CONFLICT) begin
				delay = delay + 12'(cfg.precharge_latency);
			end
		end
	end

	// counters move only when a result loads, so they match the word on rsp
	drbl_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (commit),
		.is_write  (is_write_s1),
		.delay     (delay),
		.reads     (rsp.reads_total),
		.read_sum  (rsp.read_delay_total),
		.writes    (rsp.writes_total),
		.write_sum (rsp.write_delay_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			latency_q <= delay;
			outcome_q <= outcome;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.latency = latency_q;
	assign rsp.row_outcome = outcome_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (rsp.reads_total + rsp.writes_total) ==
			($past(rsp.reads_total) + $past(rsp.writes_total) + 48'd1))
		else $error("access count did not advance by one word");

	a_hold_counts: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(rsp.reads_total) && $stable(rsp.writes_total))
		else $error("counters moved without a result load");

	a_fixed_delay: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.row_outcome == drbl_pkg::OUTC_FIXED |->
			rsp.latency == drbl_pkg::FIXED_DELAY)
		else $error("fixed mode word without fixed latency");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("input stalled with an empty input register");

endmodule

[sv/drbl_apb_regs.sv]
// ----------------------------------------------------------------------------
// drbl_apb_regs
// APB configuration registers, written on the access phase, readable back.
// ----------------------------------------------------------------------------
module drbl_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [drbl_pkg::APB_AW-1:0] paddr,
	input  logic [drbl_pkg::APB_DW-1:0] pwdata,
	output logic [drbl_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output drbl_pkg::cfg_t              cfg
);

	drbl_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.access_mode <= 1'b1;
			cfg_q.page_policy <= 1'b0;
			cfg_q.cas_latency <= 10'd45;
			cfg_q.ras_latency <= 10'd45;
			cfg_q.precharge_latency <= 10'd45;
			cfg_q.bus_latency <= 10'd10;
			cfg_q.line_size_log2 <= 4'd6;
		end else if (wr_en) begin
			case (idx)
				drbl_pkg::REG_ACCESS_MODE: cfg_q.access_mode <= pwdata[0];
				drbl_pkg::REG_PAGE_POLICY: cfg_q.page_policy <= pwdata[0];
				drbl_pkg::REG_CAS: cfg_q.cas_latency <= pwdata[drbl_pkg::TIM_W-1:0];
				drbl_pkg::REG_RAS: cfg_q.ras_latency <= pwdata[drbl_pkg::TIM_W-1:0];
				drbl_pkg::REG_PRECHARGE: cfg_q.precharge_latency <= pwdata[drbl_pkg::TIM_W-1:0];
				drbl_pkg::REG_BUS: cfg_q.bus_latency <= pwdata[drbl_pkg::TIM_W-1:0];
				drbl_pkg::REG_LINE_SIZE: cfg_q.line_size_log2 <= pwdata[drbl_pkg::LSZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			drbl_pkg::REG_ACCESS_MODE: prdata = 32'(cfg_q.access_mode);
			drbl_pkg::REG_PAGE_POLICY: prdata = 32'(cfg_q.page_policy);
			drbl_pkg::REG_CAS: prdata = 32'(cfg_q.cas_latency);
			drbl_pkg::REG_RAS: prdata = 32'(cfg_q.ras_latency);
			drbl_pkg::REG_PRECHARGE: prdata = 32'(cfg_q.precharge_latency);
			drbl_pkg::REG_BUS: prdata = 32'(cfg_q.bus_latency);
			drbl_pkg::REG_LINE_SIZE: prdata = 32'(cfg_q.line_size_log2);
			default: prdata = '0;
		endcase
	end

endmodule

[sv/drbl_bank_table.sv]
// ----------------------------------------------------------------------------
// drbl_bank_table
// Per-bank open row register file: classifies an access and opens its row.
// ----------------------------------------------------------------------------
module drbl_bank_table #(
	parameter int BANKS = 16,
	parameter int BANK_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [BANK_W-1:0]           bank,
	input  logic [drbl_pkg::ROW_W-1:0]  row,
	output logic [drbl_pkg::OUTC_W-1:0] outcome
);

	logic [BANKS-1:0]          valid_q;
	logic [drbl_pkg::ROW_W-1:0] row_q [BANKS];

	always_comb begin
		if (!valid_q[bank]) begin
			outcome = drbl_pkg::OUTC_EMPTY;
		end else if (row_q[bank] == row) begin
			outcome = drbl_pkg::OUTC_HIT;
		end else begin
			outcome = drbl_pkg::OUTC_CONFLICT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd) begin
			valid_q[bank] <= 1'b1;
		end
	end

	// rows are only looked at once the bank's valid bit is set
	always_ff @(posedge clk) begin
		if (upd && outcome != drbl_pkg::OUTC_HIT) begin
			row_q[bank] <= row;
		end
	end

endmodule

[sv/drbl_stats.sv]
// ----------------------------------------------------------------------------
// drbl_stats
// Wrapping read/write access counters and delay sums.
// ----------------------------------------------------------------------------
module drbl_stats (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic                       is_write,
	input  logic [drbl_pkg::LAT_W-1:0] delay,
	output logic [drbl_pkg::CNT_W-1:0] reads,
	output logic [drbl_pkg::CNT_W-1:0] read_sum,
	output logic [drbl_pkg::CNT_W-1:0] writes,
	output logic [drbl_pkg::CNT_W-1:0] write_sum
);

	logic [drbl_pkg::CNT_W-1:0] reads_q, read_sum_q, writes_q, write_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_q <= '0;
			read_sum_q <= '0;
			writes_q <= '0;
			write_sum_q <= '0;
		end else if (upd) begin
			if (is_write) begin
				writes_q <= writes_q + 48'd1;
				write_sum_q <= write_sum_q + 48'(delay);
			end else begin
				reads_q <= reads_q + 48'd1;
				read_sum_q <= read_sum_q + 48'(delay);
			end
		end
	end

	assign reads = reads_q;
	assign read_sum = read_sum_q;
	assign writes = writes_q;
	assign write_sum = write_sum_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dram row buffer latency model. A clocked driver
// feeds access words from a pending queue; a clocked monitor predicts each
// accepted access (bank table, timing sum, running counters) and compares
// every result word field by field. Phases cycle through timing settings,
// page policies, fixed mode and line sizes, with random idling on both sides
// and one long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NUM_BANKS   = 16;
	localparam int ROW_COLS    = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [drbl_pkg::ADDR_W-1:0] line_address;
		logic                        is_write;
	} access_t;

	typedef struct packed {
		logic [drbl_pkg::LAT_W-1:0]  latency;
		logic [drbl_pkg::OUTC_W-1:0] row_outcome;
		logic [drbl_pkg::CNT_W-1:0]  reads_total;
		logic [drbl_pkg::CNT_W-1:0]  read_delay_total;
		logic [drbl_pkg::CNT_W-1:0]  writes_total;
		logic [drbl_pkg::CNT_W-1:0]  write_delay_total;
	} lat_word_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [drbl_pkg::APB_AW-1:0] paddr;
	logic [drbl_pkg::APB_DW-1:0] pwdata;
	logic [drbl_pkg::APB_DW-1:0] prdata;
	logic                        pready;

	drbl_req_if req_if ();
	drbl_rsp_if rsp_if ();

	dram_row_buffer_latency_model u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	drbl_pkg::cfg_t             mdl_cfg;
	logic                       bank_open [NUM_BANKS];
	logic [drbl_pkg::ROW_W-1:0] bank_row [NUM_BANKS];
	logic [drbl_pkg::CNT_W-1:0] rd_count, rd_delay, wr_count, wr_delay;

	access_t   pending_access_q[$];
	lat_word_t expected_lat_q[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_requests;
	int  hold_served;
	int  hold_left;
	int  error_cnt;
	int  cycle_cnt;
	logic req_fire;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [drbl_pkg::ADDR_W-1:0] lines_per_bank_row(
		logic [drbl_pkg::LSZ_W-1:0] lsz);
		logic [drbl_pkg::ADDR_W-1:0] lines;
		lines = drbl_pkg::ADDR_W'(ROW_COLS) >> lsz;
		if (lines == 0)
			lines = drbl_pkg::ADDR_W'(1);
		return lines * drbl_pkg::ADDR_W'(NUM_BANKS);
	endfunction

	function automatic lat_word_t predict_access(access_t acc);
		lat_word_t                   w;
		int                          bank;
		logic [drbl_pkg::ROW_W-1:0]  row;
		logic [drbl_pkg::ADDR_W-1:0] quot;
		logic [drbl_pkg::LAT_W-1:0]  delay;
		logic [drbl_pkg::OUTC_W-1:0] outc;
		if (!mdl_cfg.access_mode) begin
			delay = drbl_pkg::FIXED_DELAY;
			outc = drbl_pkg::OUTC_FIXED;
		end else begin
			bank = int'(acc.line_address % NUM_BANKS);
			quot = acc.line_address / lines_per_bank_row(mdl_cfg.line_size_log2);
			row = quot[drbl_pkg::ROW_W-1:0];
			if (!bank_open[bank]) begin
				outc = drbl_pkg::OUTC_EMPTY;
				bank_open[bank] = 1'b1;
				bank_row[bank] = row;
			end else if (bank_row[bank] == row) begin
				outc = drbl_pkg::OUTC_HIT;
			end else begin
				outc = drbl_pkg::OUTC_CONFLICT;
				bank_row[bank] = row;
			end
			delay = drbl_pkg::LAT_W'(mdl_cfg.bus_latency)
				+ drbl_pkg::LAT_W'(mdl_cfg.cas_latency);
			if (mdl_cfg.page_policy || outc == drbl_pkg::OUTC_EMPTY)
				delay = delay + drbl_pkg::LAT_W'(mdl_cfg.ras_latency);
			else if (outc == drbl_pkg::OUTC_CONFLICT)
				delay = delay + drbl_pkg::LAT_W'(mdl_cfg.ras_latency)
					+ drbl_pkg::LAT_W'(mdl_cfg.precharge_latency);
		end
		if (acc.is_write) begin
			wr_count = wr_count + 1;
			wr_delay = wr_delay + drbl_pkg::CNT_W'(delay);
		end else begin
			rd_count = rd_count + 1;
			rd_delay = rd_delay + drbl_pkg::CNT_W'(delay);
		end
		w.latency = delay;
		w.row_outcome = outc;
		w.reads_total = rd_count;
		w.read_delay_total = rd_delay;
		w.writes_total = wr_count;
		w.write_delay_total = wr_delay;
		return w;
	endfunction

	task automatic check_field(string name, logic [drbl_pkg::CNT_W-1:0] want,
		logic [drbl_pkg::CNT_W-1:0] got);
		if (want !== got) begin
			error_cnt++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	// monitor: predict on accepted access words, check accepted result words
	always @(posedge clk) begin
		lat_word_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_lat_q.size() == 0) begin
					error_cnt++;
					$display("%0t: unexpected result word, actual latency %h outcome %h",
						$time, rsp_if.latency, rsp_if.row_outcome);
				end else begin
					want = expected_lat_q.pop_front();
					check_field("latency", drbl_pkg::CNT_W'(want.latency),
						drbl_pkg::CNT_W'(rsp_if.latency));
					check_field("row_outcome", drbl_pkg::CNT_W'(want.row_outcome),
						drbl_pkg::CNT_W'(rsp_if.row_outcome));
					check_field("reads_total", want.reads_total, rsp_if.reads_total);
					check_field("read_delay_total", want.read_delay_total,
						rsp_if.read_delay_total);
					check_field("writes_total", want.writes_total, rsp_if.writes_total);
					check_field("write_delay_total", want.write_delay_total,
						rsp_if.write_delay_total);
				end
			end
			if (req_if.valid && req_if.ready)
				expected_lat_q.push_back(predict_access({req_if.line_address, req_if.is_write}));
		end
		req_fire <= req_if.valid && req_if.ready;
	end

	// driver: hold the word until taken, then maybe idle
	always @(negedge clk) begin
		access_t acc;
		if (req_if.valid && !req_fire) begin
			// still waiting for ready
		end else if (pending_access_q.size() != 0
				&& $urandom_range(0, 99) >= send_idle_pct) begin
			acc = pending_access_q.pop_front();
			req_if.valid <= 1'b1;
			req_if.line_address <= acc.line_address;
			req_if.is_write <= acc.is_write;
		end else begin
			req_if.valid <= 1'b0;
		end
	end

	// receiver with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			rsp_if.ready <= 1'b0;
			hold_left <= LONG_HOLD;
			hold_served <= hold_served + 1;
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// setup phase, access phase, then an idle phase so back-to-back writes never collide
	task automatic apb_write(logic [2:0] idx, logic [drbl_pkg::APB_DW-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_access_q.size() != 0 || expected_lat_q.size() != 0 || req_if.valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [drbl_pkg::ADDR_W-1:0] rand_addr();
		return drbl_pkg::ADDR_W'({$urandom, $urandom});
	endfunction

	task automatic run_phase(drbl_pkg::cfg_t c, int send_pct, int recv_pct, bit long_hold);
		logic [drbl_pkg::ADDR_W-1:0] span, row_lim, row, offs;
		logic [drbl_pkg::ADDR_W-1:0] rows [4];
		access_t acc;
		apb_write(drbl_pkg::REG_ACCESS_MODE, drbl_pkg::APB_DW'(c.access_mode));
		apb_write(drbl_pkg::REG_PAGE_POLICY, drbl_pkg::APB_DW'(c.page_policy));
		apb_write(drbl_pkg::REG_CAS, drbl_pkg::APB_DW'(c.cas_latency));
		apb_write(drbl_pkg::REG_RAS, drbl_pkg::APB_DW'(c.ras_latency));
		apb_write(drbl_pkg::REG_PRECHARGE, drbl_pkg::APB_DW'(c.precharge_latency));
		apb_write(drbl_pkg::REG_BUS, drbl_pkg::APB_DW'(c.bus_latency));
		apb_write(drbl_pkg::REG_LINE_SIZE, drbl_pkg::APB_DW'(c.line_size_log2));
		mdl_cfg = c;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		// a few rows per phase so that hits and conflicts both come up often
		span = lines_per_bank_row(c.line_size_log2);
		row_lim = 48'hFFFF_FFFF_FFFF / span;
		rows[0] = row_lim;
		for (int i = 1; i < 4; i++)
			rows[i] = rand_addr() % (row_lim + 1);
		if (long_hold)
			hold_requests++;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 75) begin
				row = rows[$urandom_range(0, 3)];
				offs = rand_addr() % span;
				acc.line_address = row * span + offs;
			end else begin
				acc.line_address = rand_addr();
			end
			acc.is_write = 1'($urandom_range(0, 1));
			pending_access_q.push_back(acc);
		end
		wait_idle();
	endtask

	function automatic drbl_pkg::cfg_t rand_cfg(logic mode, logic policy,
		logic [drbl_pkg::LSZ_W-1:0] lsz);
		drbl_pkg::cfg_t c;
		c.access_mode = mode;
		c.page_policy = policy;
		c.cas_latency = drbl_pkg::TIM_W'($urandom_range(0, 1023));
		c.ras_latency = drbl_pkg::TIM_W'($urandom_range(0, 1023));
		c.precharge_latency = drbl_pkg::TIM_W'($urandom_range(0, 1023));
		c.bus_latency = drbl_pkg::TIM_W'($urandom_range(0, 1023));
		c.line_size_log2 = lsz;
		return c;
	endfunction

	initial begin
		access_t        acc;
		drbl_pkg::cfg_t c;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.line_address = '0;
		req_if.is_write = 1'b0;
		rsp_if.ready = 1'b0;
		req_fire = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		hold_served = 0;
		hold_left = 0;
		error_cnt = 0;
		cycle_cnt = 0;
		mdl_cfg = '{access_mode: 1'b1, page_policy: 1'b0, cas_latency: 10'd45,
			ras_latency: 10'd45, precharge_latency: 10'd45, bus_latency: 10'd10,
			line_size_log2: 4'd6};
		for (int b = 0; b < NUM_BANKS; b++) begin
			bank_open[b] = 1'b0;
			bank_row[b] = '0;
		end
		rd_count = '0;
		rd_delay = '0;
		wr_count = '0;
		wr_delay = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words on the reset settings: empty, hit, conflict, address extremes
		pending_access_q.push_back('{48'h0, 1'b0});
		pending_access_q.push_back('{48'h0, 1'b1});
		pending_access_q.push_back('{48'h100, 1'b0});
		pending_access_q.push_back('{48'h10, 1'b1});
		pending_access_q.push_back('{48'hFFFF_FFFF_FFFF, 1'b1});
		pending_access_q.push_back('{48'hFFFF_FFFF_FFFF, 1'b0});
		pending_access_q.push_back('{48'h8000_0000_0000, 1'b0});
		for (int b = 1; b < NUM_BANKS - 1; b++) begin
			acc.line_address = drbl_pkg::ADDR_W'(b) + 48'h100 * drbl_pkg::ADDR_W'(b);
			acc.is_write = b[0];
			pending_access_q.push_back(acc);
		end
		// back-to-back in one bank
		pending_access_q.push_back('{48'h1000, 1'b0});
		pending_access_q.push_back('{48'h1000, 1'b1});
		pending_access_q.push_back('{48'h2000, 1'b0});
		wait_idle();

		// all timings at their maximum, smallest lines
		c = '{access_mode: 1'b1, page_policy: 1'b0, cas_latency: 10'd1023,
			ras_latency: 10'd1023, precharge_latency: 10'd1023, bus_latency: 10'd1023,
			line_size_log2: 4'd0};
		run_phase(c, 0, 0, 1'b0);
		// closed page, zero timings, lines far larger than a row
		c = '{access_mode: 1'b1, page_policy: 1'b1, cas_latency: 10'd0,
			ras_latency: 10'd0, precharge_latency: 10'd0, bus_latency: 10'd0,
			line_size_log2: 4'd15};
		run_phase(c, 78, 0, 1'b0);
		run_phase(rand_cfg(1'b0, 1'b0, 4'd10), 0, 78, 1'b0);
		run_phase(rand_cfg(1'b1, 1'b0, 4'd3), 26, 26, 1'b0);
		run_phase(rand_cfg(1'b1, 1'b1, 4'd11), 0, 0, 1'b1);
		run_phase(rand_cfg(1'b1, 1'b0, 4'd9), 26, 26, 1'b0);
		run_phase(rand_cfg(1'b0, 1'b1, 4'd6), 78, 78, 1'b0);

		repeat (10) @(negedge clk);
		if (error_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
